### hdl/hll_pkg.sv
// Shared types, constants and helper functions for the HyperLogLog register update block.
// Used by the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hll_pkg;

  // Default number of buckets in the store.
  localparam int MAX_BUCKETS_DEF = 8192;

  // Field and register widths.
  localparam int IDX_FIELD_W = 13;
  localparam int RANK_W      = 7;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_BUCKETS = 2'd1;

  // Hash constants.
  localparam logic [63:0] MIX_C1   = 64'hcc9e2d51;
  localparam logic [63:0] MIX_C2   = 64'h1b873593;
  localparam logic [63:0] MIX_ADD  = 64'he6546b64;
  localparam logic [63:0] FIN_MUL  = 64'h85ebca6b;
  localparam logic [63:0] MA_MUL   = 64'd98765432109876543;
  localparam logic [63:0] MA_START = 64'd57548533468232177;

  // Rank given to an all-zero hash.
  localparam logic [RANK_W-1:0] RANK_ZERO = 7'd65;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MUL_MA,
    MUL_BLK,
    MUL_KC2,
    MUL_FIN,
    MUL_RCP,
    MUL_QM
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     clr;
    logic     byte_step;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     round;
    logic     prep;
    logic     sel_idx;
    logic     tz_step;
    logic     emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic last;
    logic is_read;
    logic blk_full;
    logic mul_done;
    logic tz_done;
    logic out_free;
    logic clr_last;
  } dp_stat_t;

  // Position of the lowest set bit of a nonzero byte.
  function automatic logic [2:0] ctz8(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/hll_mul.sv
// Iterative 64 x 64 multiplier that keeps the low 64 bits of the product.
// One 32 x 32 partial product per cycle; depends on no other file.
`timescale 1ns / 1ps
`default_nettype none

module hll_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);

  logic [63:0] a_q, b_q, p_q, acc_q;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] op_a, op_b;

  // Partial product order: low x low, low x high, high x low.
  assign op_a = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign op_b = (cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];

  // Sequencing control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands, product register and accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      p_q <= op_a * op_b;
      case (cnt_q)
        2'd1:    acc_q <= p_q;
        2'd2:    acc_q <= acc_q + {p_q[31:0], 32'd0};
        2'd3:    acc_q <= acc_q + {p_q[31:0], 32'd0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

### hdl/hll_dp.sv
// Datapath: hash state, shared multiplier, index reduction, rank scan and bucket memory.
// Depends on hll_pkg and hll_mul; driven by commands from hll_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module hll_dp #(
  parameter int MaxBuckets = hll_pkg::MAX_BUCKETS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire hll_pkg::dp_cmd_t                      cmd_i,
  output hll_pkg::dp_stat_t                          stat_o,
  input  wire logic                                  accept_i,
  input  wire logic                                  in_cmd_i,
  input  wire logic [7:0]                            data_byte_i,
  input  wire logic                                  last_i,
  input  wire logic [hll_pkg::IDX_FIELD_W-1:0]       read_index_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [hll_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [hll_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [hll_pkg::IDX_FIELD_W-1:0]            bucket_index_o,
  output logic [hll_pkg::RANK_W-1:0]                 bucket_value_o,
  output logic [hll_pkg::RANK_W-1:0]                 rank_o,
  output logic                                       updated_o
);

  localparam int IdxW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam logic [63:0] RecipFull = (64'd1 << 32) / 64'(MaxBuckets);
  localparam logic [31:0] Recip = RecipFull[31:0];
  localparam logic [17:0] ModM  = 18'(MaxBuckets);
  localparam int XW = hll_pkg::IDX_FIELD_W;
  localparam int RW = hll_pkg::RANK_W;

  // Configuration registers.
  logic       mode_q;
  logic [3:0] lb_q;

  // Item and hash state.
  logic                 is_read_q, last_q;
  logic [7:0]           byte_q;
  logic [XW-1:0]        ridx_q;
  logic [63:0]          rh_q, bb_q, cnt_q, k_q, h_q;
  logic [XW-1:0]        x_q, q_q;
  logic [IdxW-1:0]      idx_q, clr_ptr_q;
  logic [RW-1:0]        rank_q, rd_q;
  logic [2:0]           tz_ptr_q;
  logic                 tz_done_q;
  hll_pkg::mul_sel_e    sel_q;
  logic                 out_valid_q;

  logic [RW-1:0] mem_q [MaxBuckets];

  // Multiplier interface.
  logic        mul_done;
  logic [63:0] mul_res, mul_a, mul_b;

  logic          out_free, emit_go, upd;
  logic [2:0]    lane;
  logic [63:0]   rh_base, bb_next, sx, rnd_t, rnd_r, prep_t;
  logic [3:0]    lb_eff;
  logic [XW-1:0] hidx;
  logic [17:0]   mod_r, mod_rr;
  logic [7:0]    tz_byte;
  logic          mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [RW-1:0]   mem_wd;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_go  = cmd_i.emit && out_free;
  assign upd      = !is_read_q && (rank_q > rd_q);

  // Byte absorption: lane fill, start value at string start.
  assign lane    = cnt_q[2:0];
  assign rh_base = (cnt_q == 64'd0) ? (mode_q ? hll_pkg::MA_START : hll_pkg::MIX_C2) : rh_q;
  always_comb begin
    bb_next = ((cnt_q == 64'd0) ? 64'd0 : bb_q) | (64'(byte_q) << {lane, 3'b000});
    if (mode_q && lane == 3'd7) begin
      bb_next = 64'd0;
    end
  end
  assign sx = {{56{byte_q[7]}}, byte_q};

  // Block round and finalization prefold.
  assign rnd_t  = rh_q ^ k_q;
  assign rnd_r  = {rnd_t[50:0], rnd_t[63:51]};
  assign prep_t = rh_q ^ ((cnt_q[2:0] != 3'd0) ? k_q : 64'd0) ^ cnt_q;

  // Bucket index from the top hash bits, with the bucket count clamped.
  always_comb begin
    lb_eff = lb_q;
    if (lb_q < 4'd1) begin
      lb_eff = 4'd1;
    end else if (lb_q > 4'd13) begin
      lb_eff = 4'd13;
    end
  end
  assign hidx = h_q[63:51] >> (4'd13 - lb_eff);

  // Remainder after the reciprocal quotient; at most one correction.
  assign mod_rr = {{(18 - XW){1'b0}}, x_q} - mul_res[17:0];
  assign mod_r  = (mod_rr >= ModM) ? (mod_rr - ModM) : mod_rr;

  assign tz_byte = h_q[{tz_ptr_q, 3'b000} +: 8];

  // Multiplier operand selection.
  always_comb begin
    case (cmd_i.mul_sel)
      hll_pkg::MUL_MA:  begin mul_a = rh_q; mul_b = hll_pkg::MA_MUL; end
      hll_pkg::MUL_BLK: begin mul_a = bb_q; mul_b = hll_pkg::MIX_C1; end
      hll_pkg::MUL_KC2: begin mul_a = {k_q[48:0], k_q[63:49]}; mul_b = hll_pkg::MIX_C2; end
      hll_pkg::MUL_FIN: begin mul_a = h_q;  mul_b = hll_pkg::FIN_MUL; end
      hll_pkg::MUL_RCP: begin mul_a = 64'(x_q); mul_b = 64'(Recip); end
      hll_pkg::MUL_QM:  begin mul_a = 64'(q_q); mul_b = 64'(ModM); end
      default:          begin mul_a = 64'd0; mul_b = 64'd0; end
    endcase
  end

  hll_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_res)
  );

  // Control registers: configuration, string progress, scan, clear sweep, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      lb_q        <= 4'd13;
      cnt_q       <= 64'd0;
      tz_done_q   <= 1'b0;
      tz_ptr_q    <= 3'd0;
      clr_ptr_q   <= '0;
      out_valid_q <= 1'b0;
      sel_q       <= hll_pkg::MUL_MA;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          hll_pkg::CFG_HASH_MODE:    mode_q <= cfg_data_i[0];
          hll_pkg::CFG_LOG2_BUCKETS: lb_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.byte_step) begin
        cnt_q <= cnt_q + 64'd1;
      end
      if (cmd_i.mul_start) begin
        sel_q <= cmd_i.mul_sel;
      end
      if (cmd_i.sel_idx) begin
        tz_ptr_q  <= 3'd0;
        tz_done_q <= 1'b0;
      end else if (cmd_i.tz_step && !tz_done_q) begin
        if (tz_byte != 8'd0 || tz_ptr_q == 3'd7) begin
          tz_done_q <= 1'b1;
        end else begin
          tz_ptr_q <= tz_ptr_q + 3'd1;
        end
      end
      if (cmd_i.clr) begin
        clr_ptr_q <= clr_ptr_q + IdxW'(1);
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
        if (!is_read_q) begin
          cnt_q <= 64'd0;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      is_read_q <= in_cmd_i;
      byte_q    <= data_byte_i;
      last_q    <= last_i;
      ridx_q    <= read_index_i;
    end
    if (cmd_i.byte_step) begin
      rh_q <= rh_base;
      bb_q <= bb_next;
    end
    if (cmd_i.round) begin
      rh_q <= (rnd_r << 2) + rnd_r + hll_pkg::MIX_ADD;
      bb_q <= 64'd0;
    end
    if (cmd_i.prep) begin
      h_q <= mode_q ? rh_q : (prep_t ^ (prep_t >> 37));
    end
    if (mul_done) begin
      case (sel_q)
        hll_pkg::MUL_MA:  rh_q <= mul_res + sx;
        hll_pkg::MUL_BLK: k_q  <= mul_res;
        hll_pkg::MUL_KC2: k_q  <= mul_res;
        hll_pkg::MUL_FIN: h_q  <= mul_res ^ (mul_res >> 32);
        hll_pkg::MUL_RCP: q_q  <= mul_res[32 +: XW];
        hll_pkg::MUL_QM:  idx_q <= IdxW'(mod_r);
        default: ;
      endcase
    end
    if (cmd_i.sel_idx) begin
      x_q <= is_read_q ? ridx_q : hidx;
    end
    if (cmd_i.tz_step && !tz_done_q) begin
      if (tz_byte != 8'd0) begin
        rank_q <= RW'({tz_ptr_q, 3'b000}) + RW'(hll_pkg::ctz8(tz_byte)) + RW'(1);
      end else if (tz_ptr_q == 3'd7) begin
        rank_q <= hll_pkg::RANK_ZERO;
      end
    end
    if (emit_go) begin
      bucket_index_o <= XW'(idx_q);
      bucket_value_o <= upd ? rank_q : rd_q;
      rank_o         <= is_read_q ? '0 : rank_q;
      updated_o      <= upd;
      if (!is_read_q) begin
        rh_q <= 64'd0;
        bb_q <= 64'd0;
      end
    end
  end

  // Bucket memory: one write port, one registered read port.
  assign mem_we = cmd_i.clr || (emit_go && upd);
  assign mem_wa = cmd_i.clr ? clr_ptr_q : idx_q;
  assign mem_wd = cmd_i.clr ? '0 : rank_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[idx_q];
  end

  // Status back to the controller.
  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.last     = last_q;
    stat_o.is_read  = is_read_q;
    stat_o.blk_full = (cnt_q[2:0] == 3'd0);
    stat_o.mul_done = mul_done;
    stat_o.tz_done  = tz_done_q;
    stat_o.out_free = out_free;
    stat_o.clr_last = (clr_ptr_q == IdxW'(MaxBuckets - 1));
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hdl/hll_ctrl.sv
// Controller state machine that sequences the datapath for each transfer.
// Depends on hll_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hll_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              in_cmd_i,
  input  wire hll_pkg::dp_stat_t stat_i,
  output hll_pkg::dp_cmd_t       cmd_o,
  output logic                   in_stall_o
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_BYTE, ST_MAM, ST_CHK, ST_BLK1, ST_BLK2, ST_ROUND,
    ST_TAIL1, ST_TAIL2, ST_PREP, ST_FINM, ST_SELIDX, ST_MOD1, ST_MOD2,
    ST_TZ, ST_RDW, ST_EMIT
  } state_e;

  state_e           state_q, nxt;
  hll_pkg::dp_cmd_t cmd_q;
  logic             reissue;

  // Command issued on entry to a state.
  function automatic hll_pkg::dp_cmd_t enter_cmd(input state_e s);
    hll_pkg::dp_cmd_t c;
    c = '0;
    case (s)
      ST_CLEAR:           c.clr = 1'b1;
      ST_BYTE:            c.byte_step = 1'b1;
      ST_MAM:             begin c.mul_start = 1'b1; c.mul_sel = hll_pkg::MUL_MA; end
      ST_BLK1, ST_TAIL1:  begin c.mul_start = 1'b1; c.mul_sel = hll_pkg::MUL_BLK; end
      ST_BLK2, ST_TAIL2:  begin c.mul_start = 1'b1; c.mul_sel = hll_pkg::MUL_KC2; end
      ST_ROUND:           c.round = 1'b1;
      ST_PREP:            c.prep = 1'b1;
      ST_FINM:            begin c.mul_start = 1'b1; c.mul_sel = hll_pkg::MUL_FIN; end
      ST_SELIDX:          c.sel_idx = 1'b1;
      ST_MOD1:            begin c.mul_start = 1'b1; c.mul_sel = hll_pkg::MUL_RCP; end
      ST_MOD2:            begin c.mul_start = 1'b1; c.mul_sel = hll_pkg::MUL_QM; end
      ST_TZ:              c.tz_step = 1'b1;
      ST_EMIT:            c.emit = 1'b1;
      default:            c = '0;
    endcase
    return c;
  endfunction

  // Next-state logic.
  always_comb begin
    nxt = state_q;
    case (state_q)
      ST_CLEAR:  if (stat_i.clr_last) nxt = ST_IDLE;
      ST_IDLE:   if (accept_i) nxt = in_cmd_i ? ST_SELIDX : ST_BYTE;
      ST_BYTE:   nxt = stat_i.mode ? ST_MAM : ST_CHK;
      ST_MAM:    if (stat_i.mul_done) nxt = ST_CHK;
      ST_CHK: begin
        if (!stat_i.mode && stat_i.blk_full) begin
          nxt = ST_BLK1;
        end else if (!stat_i.last) begin
          nxt = ST_IDLE;
        end else if (!stat_i.mode && !stat_i.blk_full) begin
          nxt = ST_TAIL1;
        end else begin
          nxt = ST_PREP;
        end
      end
      ST_BLK1:   if (stat_i.mul_done) nxt = ST_BLK2;
      ST_BLK2:   if (stat_i.mul_done) nxt = ST_ROUND;
      ST_ROUND:  nxt = stat_i.last ? ST_PREP : ST_IDLE;
      ST_TAIL1:  if (stat_i.mul_done) nxt = ST_TAIL2;
      ST_TAIL2:  if (stat_i.mul_done) nxt = ST_PREP;
      ST_PREP:   nxt = stat_i.mode ? ST_SELIDX : ST_FINM;
      ST_FINM:   if (stat_i.mul_done) nxt = ST_SELIDX;
      ST_SELIDX: nxt = ST_MOD1;
      ST_MOD1:   if (stat_i.mul_done) nxt = ST_MOD2;
      ST_MOD2:   if (stat_i.mul_done) nxt = stat_i.is_read ? ST_RDW : ST_TZ;
      ST_TZ:     if (stat_i.tz_done) nxt = ST_EMIT;
      ST_RDW:    nxt = ST_EMIT;
      ST_EMIT:   if (stat_i.out_free) nxt = ST_IDLE;
      default:   nxt = ST_IDLE;
    endcase
  end

  // States whose command repeats every cycle while they last.
  assign reissue = (state_q == ST_CLEAR) || (state_q == ST_TZ) || (state_q == ST_EMIT);

  // State and registered commands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cmd_q   <= enter_cmd(ST_CLEAR);
    end else begin
      state_q <= nxt;
      if (nxt == state_q && !reissue) begin
        cmd_q <= '0;
      end else begin
        cmd_q <= enter_cmd(nxt);
      end
    end
  end

  assign cmd_o      = cmd_q;
  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### hdl/hyperloglog_register_update.sv
// HyperLogLog register update, top level.
// Input channel: in_valid_i / in_stall_o with cmd_i, data_byte_i, last_i, read_index_i.
// Each transfer is either one byte of a string (cmd_i = 0, last_i marks the end) or a
// read of one bucket (cmd_i = 1). Output channel: out_valid_o / out_stall_i with
// bucket_index_o, bucket_value_o, rank_o and updated_o; one result per last byte or read.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 hash mode, 1 log2 of bucket count) in the cycle it is high; write only while idle.
// One item is worked on at a time, and every multiply goes through one shared
// iterative 64 x 64 unit; a product holds its controller state until the unit is done.
// In mode 0 a byte that completes an 8-byte block also runs the block multiplies and
// round; in mode 1 every byte runs a multiply. A last byte adds the tail mix (mode 0,
// partial block), finalization, index reduction, the byte-serial rank scan and the
// bucket update. A read skips the hash and the rank scan.
// After reset the bucket memory is cleared one entry per cycle with in_stall_o high.
// A finished result sits in the output register while out_stall_i is high; the next
// item is taken meanwhile, and waits before its own result only if the register is
// still full.
`timescale 1ns / 1ps
`default_nettype none

module hyperloglog_register_update #(
  parameter int MaxBuckets = hll_pkg::MAX_BUCKETS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            cmd_i,
  input  wire logic [7:0]                      data_byte_i,
  input  wire logic                            last_i,
  input  wire logic [hll_pkg::IDX_FIELD_W-1:0] read_index_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [hll_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [hll_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [hll_pkg::IDX_FIELD_W-1:0]      bucket_index_o,
  output logic [hll_pkg::RANK_W-1:0]           bucket_value_o,
  output logic [hll_pkg::RANK_W-1:0]           rank_o,
  output logic                                 updated_o
);

  hll_pkg::dp_cmd_t  cmd;
  hll_pkg::dp_stat_t stat;
  logic              accept;

  assign accept = in_valid_i && !in_stall_o;

  hll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_cmd_i   (cmd_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  hll_dp #(
    .MaxBuckets (MaxBuckets)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .accept_i       (accept),
    .in_cmd_i       (cmd_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .read_index_i   (read_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bucket_index_o (bucket_index_o),
    .bucket_value_o (bucket_value_o),
    .rank_o         (rank_o),
    .updated_o      (updated_o)
  );

  // An accepted transfer keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item still starting");

  // A raised bucket holds exactly the new nonzero rank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && updated_o |-> (bucket_value_o == rank_o) && (rank_o != '0))
    else $error("updated bucket does not hold its rank");

  // A bucket left alone already holds at least the rank of the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !updated_o |-> bucket_value_o >= rank_o)
    else $error("bucket below rank without update");

  // Ranks never exceed the all-zero hash rank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rank_o <= hll_pkg::RANK_ZERO)
    else $error("rank out of range");

endmodule

`default_nettype wire
